FILE: hw/rtl/sstf_pkg.sv
// Shared types and codes for the shortest-seek-first disk request scheduler.
// Item structs, request and status codes, and the per-cell control group.
// No dependencies.
package sstf_pkg;

  localparam int unsigned TrackW = 12;
  localparam int unsigned StatW  = 32;

  typedef logic [TrackW-1:0] track_t;
  typedef logic [StatW-1:0]  stat_t;

  // Request codes carried in req_type
  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_SERVE   = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_SERVED  = 3'd2,
    ST_NONE    = 3'd3,
    ST_RESTART = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    track_t     track;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    track_t     served_track;
    track_t     seek_distance;
    stat_t      total_traversed;
    stat_t      requests_served;
    logic       queue_full;
  } out_item_t;

  // Control group from the sequencer to each queue cell
  typedef struct packed {
    logic load;   // take the appended track
    logic shift;  // take the neighbor's track (this entry or one below was removed)
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/sstf_cell.sv
// One queue cell of the scheduler: holds a single pending track.
// Loads an appended track or takes its upper neighbor's track on removal.
// Depends on sstf_pkg.
module sstf_cell
  import sstf_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  track_t     load_track_i,
  input  track_t     above_track_i,
  output track_t     track_o
);

  track_t track_q, track_d;

  // Shift down on removal, else load on append, else hold
  always_comb begin
    track_d = track_q;
    if (ctrl_i.shift) begin
      track_d = above_track_i;
    end else if (ctrl_i.load) begin
      track_d = load_track_i;
    end
  end

  always_ff @(posedge clk_i) begin
    track_q <= track_d;
  end

  assign track_o = track_q;

endmodule

FILE: hw/rtl/sstf_disk_request_scheduler.sv
// Top level of the shortest-seek-first disk request scheduler.
// Sequencer, scan compare unit, statistics and a row of sstf_cell queue cells.
// Depends on sstf_pkg and sstf_cell.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//   cfg     | input     | cfg_we_i               | cfg_data_i (start track)
//
// Add, restart and unused codes put their result in the output register in the
// cycle after they are accepted. A serve scans the batch one cell per cycle
// through the single read mux, then removes the chosen entry once the output
// register is free; an exact match ends the scan before the end of the batch.
// One item is in work at a time. Reset empties the queue, clears the
// statistics and sets the head to zero. A stalled result holds in the output
// register and the input stalls until that result is taken.
module sstf_disk_request_scheduler
  import sstf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  track_t    cfg_data_i
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SERVE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] batch_q, batch_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pick_q, pick_d;
  track_t          best_q, best_d;
  track_t          head_q, head_d;
  stat_t           sum_q, sum_d;
  stat_t           served_q, served_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  track_t          cell_track [QUEUE_DEPTH];
  cell_ctrl_t      cell_ctrl  [QUEUE_DEPTH];
  logic            add_go, remove_go;
  logic [IdxW-1:0] rd_addr;
  track_t          rd_track, seek_dist;
  logic            out_free, in_go;
  logic [StatW:0]  sum_wide;

  // Queue cells, each fed by its upper neighbor; the top cell is fed its own track
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    track_t above;
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign above = cell_track[i];
    end else begin : g_mid
      assign above = cell_track[i+1];
    end
    assign cell_ctrl[i].load  = add_go && (count_q == CntW'(i));
    assign cell_ctrl[i].shift = remove_go && (IdxW'(i) >= pick_q);
    sstf_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[i]),
      .load_track_i  (in_item_i.track),
      .above_track_i (above),
      .track_o       (cell_track[i])
    );
  end

  // Read one cell: scan index while scanning, chosen entry while serving
  assign rd_addr   = (state_q == S_SCAN) ? idx_q : pick_q;
  assign rd_track  = cell_track[rd_addr];
  assign seek_dist = (head_q >= rd_track) ? (head_q - rd_track) : (rd_track - head_q);
  assign sum_wide  = {1'b0, sum_q} + {{(StatW + 1 - TrackW){1'b0}}, best_q};

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_go      = in_valid_i && !in_stall_o;
  assign add_go     = in_go && (in_item_i.req_type == REQ_ADD) && (count_q != DepthCnt);
  assign remove_go  = (state_q == S_SERVE) && out_free;

  // Sequencer, scan compare and statistics
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    batch_d     = batch_q;
    idx_d       = idx_q;
    pick_d      = pick_q;
    best_d      = best_q;
    head_d      = head_q;
    sum_d       = sum_q;
    served_d    = served_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_go) begin
          out_valid_d           = 1'b1;
          out_d.status          = ST_NONE;
          out_d.served_track    = '0;
          out_d.seek_distance   = '0;
          case (in_item_i.req_type)
            REQ_ADD: begin
              if (count_q == DepthCnt) begin
                out_d.status = ST_FULL;
              end else begin
                count_d      = count_q + CntW'(1);
                out_d.status = ST_ADDED;
              end
            end
            REQ_SERVE: begin
              if (count_q != '0) begin
                out_valid_d = 1'b0;
                if ((batch_q == '0) || (batch_q > count_q)) begin
                  batch_d = count_q;
                end
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            REQ_RESTART: begin
              count_d      = '0;
              batch_d      = '0;
              sum_d        = '0;
              served_d     = '0;
              head_d       = in_item_i.track;
              out_d.status = ST_RESTART;
            end
            default: begin
              out_d.status = ST_NONE;
            end
          endcase
          out_d.total_traversed = sum_d;
          out_d.requests_served = served_d;
          out_d.queue_full      = (count_d == DepthCnt);
        end else if (cfg_we_i) begin
          head_d = cfg_data_i;
        end
      end
      S_SCAN: begin
        // Keep the first smallest distance; stop on an exact match or at the batch end
        if ((idx_q == '0) || (seek_dist < best_q)) begin
          best_d = seek_dist;
          pick_d = idx_q;
        end
        if ((seek_dist == '0) || ((CntW'(idx_q) + CntW'(1)) == batch_q)) begin
          state_d = S_SERVE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_SERVE: begin
        if (out_free) begin
          count_d  = count_q - CntW'(1);
          batch_d  = batch_q - CntW'(1);
          head_d   = rd_track;
          sum_d    = sum_wide[StatW] ? '1 : sum_wide[StatW-1:0];
          served_d = (served_q == '1) ? served_q : served_q + StatW'(1);
          out_valid_d           = 1'b1;
          out_d.status          = ST_SERVED;
          out_d.served_track    = rd_track;
          out_d.seek_distance   = best_q;
          out_d.total_traversed = sum_d;
          out_d.requests_served = served_d;
          out_d.queue_full      = 1'b0;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      batch_q     <= '0;
      head_q      <= '0;
      sum_q       <= '0;
      served_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      batch_q     <= batch_d;
      head_q      <= head_d;
      sum_q       <= sum_d;
      served_q    <= served_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Scan and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pick_q <= pick_d;
    best_q <= best_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the shortest-seek-first disk request scheduler.
// Checks every result item against an in-bench scheduler model under random idling.
// Depends on sstf_pkg and sstf_disk_request_scheduler.
`timescale 1ns / 100ps

module tb_top;
  import sstf_pkg::*;

  localparam int QueueDepth = 16;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int RandomPhases = 6;
  localparam int PhaseItems = 175;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  track_t    cfg_data_i = '0;

  // Scheduler model state
  track_t pend_tracks [QueueDepth];
  int     pend_count = 0;
  int     batch_left = 0;
  track_t head_pos = '0;
  stat_t  seek_total = '0;
  stat_t  serve_total = '0;

  // Results still owed by the block, oldest first
  out_item_t due_results [$];

  int  errors = 0;
  int  n_sent = 0;
  int  n_loads = 0;
  int  n_served = 0;
  int  n_rejects = 0;
  int  n_restarts = 0;
  int  n_idle = 0;
  bit  no_gaps = 1'b0;
  bit  quiet_stall = 1'b0;
  int  stall_hold = 0;
  int  stall_roll;

  sstf_disk_request_scheduler #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic track_t seek_span(input track_t a, input track_t b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the scheduler model by one request and return the result it owes
  function automatic out_item_t predict_schedule(input in_item_t it);
    out_item_t res;
    int        i;
    int        pick;
    track_t    best;
    track_t    d;
    res = '0;
    res.status = ST_NONE;
    case (it.req_type)
      REQ_ADD: begin
        if (pend_count >= QueueDepth) begin
          res.status = ST_FULL;
        end else begin
          pend_tracks[pend_count] = it.track;
          pend_count++;
          res.status = ST_ADDED;
        end
      end
      REQ_SERVE: begin
        if (pend_count > 0) begin
          if (batch_left == 0 || batch_left > pend_count) batch_left = pend_count;
          // first entry with the smallest distance; an exact match is distance zero
          pick = 0;
          best = seek_span(head_pos, pend_tracks[0]);
          for (i = 1; i < batch_left; i++) begin
            d = seek_span(head_pos, pend_tracks[i]);
            if (d < best) begin
              best = d;
              pick = i;
            end
          end
          res.served_track = pend_tracks[pick];
          res.seek_distance = best;
          for (i = pick; i + 1 < pend_count; i++) pend_tracks[i] = pend_tracks[i + 1];
          pend_count--;
          batch_left--;
          head_pos = res.served_track;
          if (seek_total > 32'hFFFF_FFFF - stat_t'(best)) seek_total = '1;
          else seek_total = seek_total + stat_t'(best);
          if (serve_total != '1) serve_total++;
          res.status = ST_SERVED;
        end
      end
      REQ_RESTART: begin
        pend_count = 0;
        batch_left = 0;
        seek_total = '0;
        serve_total = '0;
        head_pos = it.track;
        res.status = ST_RESTART;
      end
      default: ;
    endcase
    res.total_traversed = seek_total;
    res.requests_served = serve_total;
    res.queue_full = (pend_count >= QueueDepth);
    return res;
  endfunction

  // Offer one item, hold it until taken, then record what it owes
  task automatic issue_request(input logic [1:0] code, input track_t trk);
    in_item_t it;
    it.req_type = code;
    it.track = trk;
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    due_results.push_back(predict_schedule(it));
    n_sent++;
  endtask

  // Drop valid for a random gap: mostly none or short, sometimes long
  task automatic pause_sender();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 40);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off until every owed result is back and a serve scan would have ended
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (QueueDepth + 2) @(posedge clk_i);
  endtask

  task automatic load_start_track(input track_t v);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    head_pos = v;
    n_loads++;
  endtask

  // Track choice: extremes, copies of queued tracks, near the head, or anywhere
  function automatic track_t pick_track();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 28 && pend_count > 0) return pend_tracks[$urandom_range(0, pend_count - 1)];
    if (r < 50) return head_pos + track_t'($urandom_range(0, 32)) - track_t'(16);
    return track_t'($urandom());
  endfunction

  task automatic test_empty_and_unused();
    issue_request(REQ_SERVE, '1);
    issue_request(ReqUnused, '1);
    issue_request(ReqUnused, '0);
  endtask

  // Fill the queue with extremes, a distance tie, an exact match and a duplicate
  task automatic test_fill_and_reject();
    track_t fill [QueueDepth];
    int     i;
    fill = '{12'h7F8, 12'h808, 12'hFFF, 12'h000, 12'h555, 12'hAAA, 12'h7F0, 12'h810,
             12'h800, 12'h123, 12'hEDC, 12'h7F8, 12'h001, 12'hFFE, 12'h3C3, 12'hC3C};
    load_start_track(12'h800);
    for (i = 0; i < QueueDepth; i++) issue_request(REQ_ADD, fill[i]);
    issue_request(REQ_ADD, 12'h123);
  endtask

  task automatic test_serve_and_restart();
    repeat (3) issue_request(REQ_SERVE, '0);
    issue_request(REQ_RESTART, '1);
    issue_request(REQ_SERVE, '0);
  endtask

  // Mostly fill/drain cycles with random content, some restarts and unused codes
  task automatic test_random_mix(input int count, input bit calm);
    int         k;
    int         r;
    bit         filling;
    logic [1:0] code;
    no_gaps = calm;
    quiet_stall = calm;
    filling = 1'b1;
    for (k = 0; k < count; k++) begin
      if (pend_count == QueueDepth && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (pend_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 2) code = REQ_RESTART;
      else if (r < 4) code = ReqUnused;
      else if (r < (filling ? 70 : 30)) code = REQ_ADD;
      else code = REQ_SERVE;
      issue_request(code, pick_track());
      pause_sender();
    end
    no_gaps = 1'b0;
    quiet_stall = 1'b0;
  endtask

  // Output stall: random on/off runs, occasionally long, none while quiet
  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (quiet_stall || stall_roll < 55) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(0, 6);
      end else if (stall_roll < 93) begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(10, 30);
      end
    end
  end

  task automatic match_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each taken result with the oldest owed one
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result item with none owed: status %0d", out_item_o.status);
        errors++;
      end else begin
        want = due_results.pop_front();
        match_field("status", want.status, out_item_o.status);
        match_field("served_track", want.served_track, out_item_o.served_track);
        match_field("seek_distance", want.seek_distance, out_item_o.seek_distance);
        match_field("total_traversed", want.total_traversed, out_item_o.total_traversed);
        match_field("requests_served", want.requests_served, out_item_o.requests_served);
        match_field("queue_full", want.queue_full, out_item_o.queue_full);
        case (want.status)
          ST_SERVED:  n_served++;
          ST_FULL:    n_rejects++;
          ST_RESTART: n_restarts++;
          ST_NONE:    n_idle++;
          default: ;
        endcase
      end
    end
  end

  initial begin
    int   ph;
    track_t starts [RandomPhases];
    starts = '{12'hFFF, 12'h000, 12'h800, 12'h001, 12'hFFE, 12'h000};
    starts[3] = track_t'($urandom());
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_fill_and_reject();
    test_serve_and_restart();
    for (ph = 0; ph < RandomPhases; ph++) begin
      load_start_track(starts[ph]);
      test_random_mix(PhaseItems, ph == 2);
    end

    wait_drained();
    $display("Sent %0d requests across %0d start-track loads and %0d random phases.",
             n_sent, n_loads, RandomPhases);
    $display("Checked %0d serves, %0d full rejects, %0d restarts, %0d empty or unused replies.",
             n_served, n_rejects, n_restarts, n_idle);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sstf_pkg.sv
hw/rtl/sstf_cell.sv
hw/rtl/sstf_disk_request_scheduler.sv
bench/tb_top.sv
